/* rtl/fwt_pkg.sv */
package fwt_pkg;

    localparam int SIZE_DEF       = 4096;
    localparam int VALUE_BITS_DEF = 32;
    localparam int POS_W          = 13;
    localparam int WORD_W         = 32;

    localparam logic [WORD_W-1:0] MODULUS_RESET = 32'd1000000007;

    localparam logic ACT_QUERY = 1'b0;
    localparam logic ACT_ADD   = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_RANGE     = 2'd1,
        ST_UNREDUCED = 2'd2
    } t_status;

    typedef struct packed {
        logic [WORD_W-1:0] total;
        t_status           status;
    } t_result;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage

/* rtl/modular_fenwick_tree_top.sv */
// Modular Fenwick tree over SIZE one-based nodes held in one synchronous RAM
// (one read and one write port, read data registered). After reset the RAM is
// swept to zero, one node a cycle, and no word is taken until the sweep is
// done; the modulus may be written meanwhile. An update walks upward and a
// query walks downward, one node per cycle; an update reads, adds, reduces
// and writes back each node, a query only reads, adds and reduces. Rejected
// words and a query at position zero skip the walk. One word is worked on at
// a time; a finished result waits in the output register while the next
// word is taken.
module modular_fenwick_tree_top #(
    parameter int SIZE       = fwt_pkg::SIZE_DEF,
    parameter int VALUE_BITS = fwt_pkg::VALUE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fwt_pkg::WORD_W-1:0] i_cfg_wdata,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_action,
    input  logic [fwt_pkg::POS_W-1:0]  i_position,
    input  logic [fwt_pkg::WORD_W-1:0] i_amount,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [fwt_pkg::WORD_W-1:0] o_prefix_total,
    output logic [1:0]                 o_status
);

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;

    logic [fwt_pkg::WORD_W-1:0] r_modulus;
    logic                       r_out_valid;
    fwt_pkg::t_result           r_out;

    fwt_pkg::t_hs               res_hs;
    fwt_pkg::t_result           res;
    logic                       res_ready;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VALUE_BITS-1:0]      ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VALUE_BITS-1:0]      ram_rdata;

    assign res_ready = !r_out_valid || i_ready;

    fwt_seq #(
        .SIZE       (SIZE),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_modulus   (r_modulus),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_action    (i_action),
        .i_position  (i_position),
        .i_amount    (i_amount),
        .o_res_hs    (res_hs),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    fwt_ram #(
        .DEPTH (SIZE),
        .WIDTH (VALUE_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus   <= fwt_pkg::MODULUS_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (res_hs.valid && res_hs.ready) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_prefix_total = r_out.total;
    assign o_status       = r_out.status;

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_ready)
        else $error("word taken during clearing sweep");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("second word taken while one is in flight");

    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !o_ready)
        else $error("node write while idle");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_hs.valid && res_ready) |=> o_valid)
        else $error("result lost on way to output register");

endmodule

/* rtl/fwt_ram.sv */
module fwt_ram #(
    parameter int DEPTH = fwt_pkg::SIZE_DEF,
    parameter int WIDTH = fwt_pkg::VALUE_BITS_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/fwt_seq.sv */
module fwt_seq #(
    parameter int SIZE       = fwt_pkg::SIZE_DEF,
    parameter int VALUE_BITS = fwt_pkg::VALUE_BITS_DEF,
    localparam int AW        = (SIZE > 1) ? $clog2(SIZE) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [fwt_pkg::WORD_W-1:0]    i_modulus,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_action,
    input  logic [fwt_pkg::POS_W-1:0]     i_position,
    input  logic [fwt_pkg::WORD_W-1:0]    i_amount,
    output fwt_pkg::t_hs                  o_res_hs,
    input  logic                          i_res_ready,
    output fwt_pkg::t_result              o_res,
    output logic                          o_ram_we,
    output logic [AW-1:0]                 o_ram_waddr,
    output logic [VALUE_BITS-1:0]         o_ram_wdata,
    output logic [AW-1:0]                 o_ram_raddr,
    input  logic [VALUE_BITS-1:0]         i_ram_rdata
);

    localparam int IW = AW + 2;
    localparam int CW = (VALUE_BITS + 1 > fwt_pkg::WORD_W) ? VALUE_BITS + 1 : fwt_pkg::WORD_W;
    localparam logic [31:0]   SIZE_W    = 32'(SIZE);
    localparam logic [IW-1:0] SIZE_I    = IW'(SIZE);
    localparam logic [AW-1:0] CLR_LAST  = AW'(SIZE - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [AW-1:0]         r_clr;
    logic [IW-1:0]         r_idx;
    logic                  r_is_add;
    logic [VALUE_BITS-1:0] r_amount;
    logic [VALUE_BITS-1:0] r_total;
    logic [31:0]           r_res_total;
    fwt_pkg::t_status      r_res_status;

    logic                  accept;
    logic                  pos_over;
    logic [IW-1:0]         pos_i;
    logic [VALUE_BITS-1:0] operand;
    logic [CW-1:0]         sum;
    logic [CW-1:0]         mod_ext;
    logic [CW-1:0]         reduced;
    logic [VALUE_BITS-1:0] node_new;
    logic [IW-1:0]         idx_up;
    logic [IW-1:0]         idx_down;
    logic [IW-1:0]         idx_next;
    logic [IW-1:0]         idx_m1;
    logic [IW-1:0]         pos_m1;
    logic [IW-1:0]         next_m1;
    logic                  walk_end;

    assign accept   = (r_state == S_IDLE) && i_valid;
    assign pos_over = 32'(i_position) > SIZE_W;
    assign pos_i    = IW'(i_position);

    // modular add, one conditional subtract
    assign operand  = r_is_add ? r_amount : r_total;
    assign sum      = CW'(i_ram_rdata) + CW'(operand);
    assign mod_ext  = CW'(i_modulus);
    assign reduced  = (sum >= mod_ext) ? (sum - mod_ext) : sum;
    assign node_new = reduced[VALUE_BITS-1:0];

    assign idx_up   = r_idx + (r_idx & (~r_idx + IW'(1)));
    assign idx_down = r_idx & (r_idx - IW'(1));
    assign idx_next = r_is_add ? idx_up : idx_down;
    assign walk_end = r_is_add ? (idx_up > SIZE_I) : (idx_down == '0);
    assign idx_m1   = r_idx - IW'(1);
    assign pos_m1   = pos_i - IW'(1);
    assign next_m1  = idx_next - IW'(1);

    always_comb begin
        o_ram_raddr = (r_state == S_IDLE) ? pos_m1[AW-1:0] : next_m1[AW-1:0];
        o_ram_we    = (r_state == S_CLEAR) || ((r_state == S_WALK) && r_is_add);
        o_ram_waddr = (r_state == S_CLEAR) ? r_clr : idx_m1[AW-1:0];
        o_ram_wdata = (r_state == S_CLEAR) ? '0 : node_new;
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_res_hs.valid = (r_state == S_DONE);
    assign o_res_hs.ready = i_res_ready;
    assign o_res.total    = r_res_total;
    assign o_res.status   = r_res_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx        <= pos_i;
                        r_is_add     <= (i_action == fwt_pkg::ACT_ADD);
                        r_amount     <= VALUE_BITS'(i_amount);
                        r_total      <= '0;
                        r_res_total  <= '0;
                        if (i_action == fwt_pkg::ACT_ADD) begin
                            if (pos_over || i_position == '0) begin
                                r_res_status <= fwt_pkg::ST_RANGE;
                                r_state      <= S_DONE;
                            end else if (i_amount >= i_modulus) begin
                                r_res_status <= fwt_pkg::ST_UNREDUCED;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= fwt_pkg::ST_OK;
                                r_state      <= S_WALK;
                            end
                        end else begin
                            if (pos_over) begin
                                r_res_status <= fwt_pkg::ST_RANGE;
                                r_state      <= S_DONE;
                            end else if (i_position == '0) begin
                                r_res_status <= fwt_pkg::ST_OK;
                                r_state      <= S_DONE;
                            end else begin
                                r_res_status <= fwt_pkg::ST_OK;
                                r_state      <= S_WALK;
                            end
                        end
                    end
                end
                S_WALK: begin
                    r_idx <= idx_next;
                    if (!r_is_add) begin
                        r_total <= node_new;
                    end
                    if (walk_end) begin
                        r_res_total <= r_is_add ? '0 : 32'(node_new);
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* sim/modular_fenwick_tree_top_tb.sv */
`timescale 1ns / 1ps

module modular_fenwick_tree_top_tb;

    localparam int NODES         = fwt_pkg::SIZE_DEF;
    localparam int SETTLE_CYCLES = 20;
    localparam int SEGMENTS      = 12;
    localparam int SEGMENT_WORDS = 80;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [fwt_pkg::WORD_W-1:0] i_cfg_wdata = '0;
    logic                       i_valid     = 1'b0;
    logic                       o_ready;
    logic                       i_action    = fwt_pkg::ACT_QUERY;
    logic [fwt_pkg::POS_W-1:0]  i_position  = '0;
    logic [fwt_pkg::WORD_W-1:0] i_amount    = '0;
    logic                       o_valid;
    logic                       i_ready     = 1'b0;
    logic [fwt_pkg::WORD_W-1:0] o_prefix_total;
    logic [1:0]                 o_status;

    logic [fwt_pkg::WORD_W-1:0] shadow_nodes [1:NODES];
    logic [fwt_pkg::WORD_W-1:0] modulus_now = fwt_pkg::MODULUS_RESET;
    fwt_pkg::t_result           pending_sums [$];
    int                         mismatch_count = 0;
    int                         results_seen   = 0;
    int                         src_idle_pct   = 0;
    int                         sink_idle_pct  = 0;

    modular_fenwick_tree_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_position    (i_position),
        .i_amount      (i_amount),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_prefix_total(o_prefix_total),
        .o_status      (o_status)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int k = 1; k <= NODES; k++) begin
            shadow_nodes[k] = '0;
        end
    end

    // one add and one conditional subtract, kept to the word width
    function automatic logic [fwt_pkg::WORD_W-1:0] fold_mod(
            input logic [fwt_pkg::WORD_W-1:0] a,
            input logic [fwt_pkg::WORD_W-1:0] b);
        logic [fwt_pkg::WORD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, modulus_now}) begin
            s = s - {1'b0, modulus_now};
        end
        return s[fwt_pkg::WORD_W-1:0];
    endfunction

    function automatic fwt_pkg::t_result fenwick_apply(
            input logic                       act,
            input logic [fwt_pkg::POS_W-1:0]  pos,
            input logic [fwt_pkg::WORD_W-1:0] amt);
        fwt_pkg::t_result r;
        int               idx;
        r.total  = '0;
        r.status = fwt_pkg::ST_OK;
        idx      = int'(pos);
        if (act == fwt_pkg::ACT_QUERY) begin
            if (idx > NODES) begin
                r.status = fwt_pkg::ST_RANGE;
            end else begin
                while (idx > 0) begin
                    r.total = fold_mod(r.total, shadow_nodes[idx]);
                    idx     = idx - (idx & -idx);
                end
            end
        end else begin
            if (idx == 0 || idx > NODES) begin
                r.status = fwt_pkg::ST_RANGE;
            end else if (amt >= modulus_now) begin
                r.status = fwt_pkg::ST_UNREDUCED;
            end else begin
                while (idx <= NODES) begin
                    shadow_nodes[idx] = fold_mod(shadow_nodes[idx], amt);
                    idx               = idx + (idx & -idx);
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    // leaves valid high on return; caller sends again or lowers it in the same step
    task automatic send_word(input logic act, input logic [fwt_pkg::POS_W-1:0] pos,
                             input logic [fwt_pkg::WORD_W-1:0] amt);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_position <= pos;
        i_amount   <= amt;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_sums.push_back(fenwick_apply(act, pos, amt));
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (pending_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_modulus(input logic [fwt_pkg::WORD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        modulus_now = value;
    endtask

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin : result_check
        fwt_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("result word with nothing outstanding");
            end else begin
                want = pending_sums.pop_front();
                if (o_prefix_total !== want.total) begin
                    report_mismatch($sformatf("prefix_total got %h want %h",
                                              o_prefix_total, want.total));
                end
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                end
            end
            results_seen++;
        end
    end

    task automatic test_query_and_add_extremes();
        logic [fwt_pkg::WORD_W-1:0] top;
        top = modulus_now - 32'd1;
        send_word(fwt_pkg::ACT_QUERY, 13'd0, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd4096, 32'd0);
        send_word(fwt_pkg::ACT_ADD, 13'd1, top);
        send_word(fwt_pkg::ACT_ADD, 13'd4096, top);
        send_word(fwt_pkg::ACT_ADD, 13'd2048, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd1, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd4096, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd4095, 32'd0);
        drain_and_settle();
    endtask

    task automatic test_rejections();
        send_word(fwt_pkg::ACT_ADD, 13'd0, 32'd5);
        send_word(fwt_pkg::ACT_ADD, 13'd4097, 32'd5);
        send_word(fwt_pkg::ACT_ADD, 13'd8191, 32'hFFFF_FFFF);
        send_word(fwt_pkg::ACT_ADD, 13'd0, modulus_now);
        send_word(fwt_pkg::ACT_ADD, 13'd7, modulus_now);
        send_word(fwt_pkg::ACT_ADD, 13'd7, 32'hFFFF_FFFF);
        send_word(fwt_pkg::ACT_QUERY, 13'd4097, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd8191, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd0, 32'hFFFF_FFFF);
        drain_and_settle();
    endtask

    // nodes left above a smaller modulus
    task automatic test_modulus_shrink();
        write_modulus(32'hFFFF_FFFF);
        send_word(fwt_pkg::ACT_ADD, 13'd3, 32'hFFFF_FFFE);
        send_word(fwt_pkg::ACT_ADD, 13'd5, 32'h8000_0000);
        send_word(fwt_pkg::ACT_ADD, 13'd4096, 32'hFFFF_FFFE);
        send_word(fwt_pkg::ACT_QUERY, 13'd4096, 32'd0);
        drain_and_settle();
        write_modulus(32'd2);
        send_word(fwt_pkg::ACT_QUERY, 13'd4096, 32'd0);
        send_word(fwt_pkg::ACT_QUERY, 13'd8, 32'd0);
        send_word(fwt_pkg::ACT_ADD, 13'd1, 32'd1);
        send_word(fwt_pkg::ACT_QUERY, 13'd4095, 32'd0);
        drain_and_settle();
    endtask

    task automatic test_random_traffic();
        logic [fwt_pkg::WORD_W-1:0] moduli [SEGMENTS];
        logic                       act;
        logic [fwt_pkg::POS_W-1:0]  pos;
        logic [fwt_pkg::WORD_W-1:0] amt;
        int                         sel;
        moduli = '{32'hFFFF_FFFF, 32'd1000000007, 32'd97, 32'd0,
                   32'd2, 32'd0, 32'h8000_0000, 32'd65537,
                   32'd3, 32'd0, 32'hFFFF_FFFF, 32'd1000000007};
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            case (seg / 4)
                0: begin
                    src_idle_pct  = 28;
                    sink_idle_pct = 53;
                end
                1: begin
                    src_idle_pct  = 53;
                    sink_idle_pct = 28;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            if (moduli[seg] == 32'd0) begin
                moduli[seg] = (seg == 5) ? $urandom_range(2, 1000)
                                         : $urandom_range(2, 32'hFFFF_FFFF);
            end
            write_modulus(moduli[seg]);
            for (int n = 0; n < SEGMENT_WORDS; n++) begin
                act = 1'($urandom_range(0, 1));
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    pos = 13'd0;
                end else if (sel < 6) begin
                    pos = 13'd4096;
                end else if (sel < 9) begin
                    pos = 13'($urandom_range(4097, 8191));
                end else if (sel < 20) begin
                    pos = 13'($urandom_range(1, 16));
                end else begin
                    pos = 13'($urandom_range(1, 4096));
                end
                sel = $urandom_range(0, 99);
                if (act == fwt_pkg::ACT_QUERY || sel >= 93) begin
                    amt = $urandom;
                end else if (sel < 80) begin
                    amt = $urandom % modulus_now;
                end else if (sel < 85) begin
                    amt = modulus_now - 32'd1;
                end else if (sel < 88) begin
                    amt = 32'd0;
                end else begin
                    amt = modulus_now;
                end
                send_word(act, pos, amt);
            end
            drain_and_settle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_query_and_add_extremes();
        test_rejections();
        test_modulus_shrink();
        test_random_traffic();
        drain_and_settle();
        if (pending_sums.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
        end
        if (mismatch_count == 0) begin
            $display("modular_fenwick_tree_top_tb: PASS");
        end else begin
            $display("modular_fenwick_tree_top_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout");
        $display("modular_fenwick_tree_top_tb: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fwt_pkg.sv
rtl/fwt_ram.sv
rtl/fwt_seq.sv
rtl/modular_fenwick_tree_top.sv
sim/modular_fenwick_tree_top_tb.sv
